FILE: hdl/twpg_pkg.sv
// Shared types and constants for the time window packet gate.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package twpg_pkg;

   localparam int ELAPSED_W = 32;
   localparam int IV_W      = 17;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_BYTE = 2'd1;
   localparam logic [1:0] ACT_LOAD = 2'd2;

   localparam logic CSR_GOOD_WINDOW = 1'b0;
   localparam logic CSR_SCHED_LEN   = 1'b1;

   localparam logic [5:0] HDR_MIN = 6'd20;
   localparam logic [6:0] UDP_HDR = 7'd8;

   typedef struct packed {
      logic                 borrow;
      logic [ELAPSED_W-1:0] diff;
   } sub_res_type;

endpackage

`default_nettype wire

FILE: hdl/twpg_sub.sv
// Shared 32-bit subtract and compare unit: a - b with borrow (a < b).
// Depends on twpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twpg_sub (
   input  wire logic [twpg_pkg::ELAPSED_W-1:0] a,
   input  wire logic [twpg_pkg::ELAPSED_W-1:0] b,
   output twpg_pkg::sub_res_type               res
);
   import twpg_pkg::*;

   logic [ELAPSED_W:0] full;

   assign full       = {1'b0, a} - {1'b0, b};
   assign res.borrow = full[ELAPSED_W];
   assign res.diff   = full[ELAPSED_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/twpg_table.sv
// Interval table: single write port, registered read port.
// Depends on twpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twpg_table #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [twpg_pkg::IV_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [twpg_pkg::IV_W-1:0] rd_data
);
   import twpg_pkg::*;

   logic [IV_W-1:0] mem_ff [DEPTH];
   logic [IV_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/time_window_packet_gate.sv
// Time window packet gate: a non-final packet byte, tick or load is handled while idle.
// A final packet byte walks the schedule, then the finish state loads the result register;
// each walk step is one table read and one pass through the shared subtractor.
// While idle, one request per cycle is taken if the result register is empty or drains.
// Reset is synchronous: counters, position and parser clear; the table is undefined
// until loaded.
`timescale 1ns / 1ps
`default_nettype none

module time_window_packet_gate #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // data_byte[7:0], entry_index[13:8], entry_value[29:14]
   input  wire logic [1:0]  req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // payload_byte
   output logic [2:0]       rsp_tuser,   // byte_valid, forward, malformed
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);
   import twpg_pkg::*;

   localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW    = (POS_W + 1 > 7) ? POS_W + 1 : 7;
   localparam int IW    = ((POS_W > 6) ? POS_W : 6) + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [15:0]          offset_ff, offset_in;
   logic [5:0]           header_ff, header_in;
   logic [15:0]          pkt_len_ff, pkt_len_in;
   logic [7:0]           gw_ff, gw_in;
   logic [6:0]           slen_ff, slen_in;
   logic                 bad_ff, bad_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [7:0]           pend_data_ff, pend_data_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]           rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]           rsp_tuser_ff, rsp_tuser_in;
   logic                 rsp_tlast_ff, rsp_tlast_in;

   logic [1:0]           action;
   logic [7:0]           data_byte;
   logic [5:0]           entry_index;
   logic [15:0]          entry_value;
   logic                 req_fire, out_free;

   logic [5:0]           ihl_bytes, hdr_new;
   logic [15:0]          pkt_new;
   logic [16:0]          hdr_plus, off_plus, end_len;
   logic                 byte_valid, byte_last, byte_bad;

   logic [IW-1:0]        idx_wide;
   logic                 tbl_wr;
   logic [IV_W-1:0]      tbl_wdata, iv;
   logic [ELAPSED_W-1:0] sub_b;
   sub_res_type          sub_res;
   logic [POS_W:0]       nxt;
   logic                 nxt_wrap, walk_stop;

   assign action      = req_tuser;
   assign data_byte   = req_tdata[7:0];
   assign entry_index = req_tdata[13:8];
   assign entry_value = req_tdata[29:14];

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // header parse for the byte on the input
   assign ihl_bytes = {data_byte[3:0], 2'b00};
   always_comb begin
      hdr_new = header_ff;
      if (offset_ff == 16'd0) begin
         hdr_new = (ihl_bytes < HDR_MIN) ? HDR_MIN : ihl_bytes;
      end
      pkt_new = pkt_len_ff;
      if (offset_ff == 16'd2) begin
         pkt_new = {data_byte, pkt_len_ff[7:0]};
      end else if (offset_ff == 16'd3) begin
         pkt_new = {pkt_len_ff[15:8], data_byte};
      end
   end

   assign hdr_plus   = {10'd0, {1'b0, hdr_new} + UDP_HDR};
   assign off_plus   = {1'b0, offset_ff} + 17'd1;
   assign end_len    = (pkt_new < {10'd0, hdr_new}) ? {11'd0, hdr_new} : {1'b0, pkt_new};
   assign byte_valid = ({1'b0, offset_ff} >= hdr_plus) && (offset_ff < pkt_new);
   assign byte_last  = (offset_ff >= 16'd3) && (off_plus >= end_len);
   assign byte_bad   = {1'b0, pkt_new} < hdr_plus;

   // schedule table
   assign idx_wide  = IW'(entry_index);
   assign tbl_wr    = req_fire && (action == ACT_LOAD) && (idx_wide < IW'(MAX_ENTRIES));
   assign tbl_wdata = {1'b0, entry_value} + {9'd0, gw_ff};

   twpg_table #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (POS_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (idx_wide[POS_W-1:0]),
      .wr_data (tbl_wdata),
      .rd_addr (pos_ff),
      .rd_data (iv)
   );

   // shared subtractor: tick increment, walk step, window compare
   always_comb begin
      unique case (state_ff)
         ST_CMP:  sub_b = {{(ELAPSED_W-IV_W){1'b0}}, iv};
         ST_FIN:  sub_b = {{(ELAPSED_W-8){1'b0}}, gw_ff};
         default: sub_b = {ELAPSED_W{1'b1}};
      endcase
   end

   twpg_sub u_sub (
      .a   (elapsed_ff),
      .b   (sub_b),
      .res (sub_res)
   );

   assign nxt       = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};
   assign nxt_wrap  = (CW'(nxt) >= CW'(slen_ff)) || (CW'(nxt) >= CW'(MAX_ENTRIES));
   assign walk_stop = (iv == '0) || sub_res.borrow;

   always_comb begin
      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      pos_in        = pos_ff;
      offset_in     = offset_ff;
      header_in     = header_ff;
      pkt_len_in    = pkt_len_ff;
      gw_in         = gw_ff;
      slen_in       = slen_ff;
      bad_in        = bad_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GOOD_WINDOW: gw_in   = csr_data;
            CSR_SCHED_LEN:   slen_in = csr_data[6:0];
            default:         gw_in   = gw_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && action == ACT_TICK) begin
               if (elapsed_ff != {ELAPSED_W{1'b1}}) begin
                  elapsed_in = sub_res.diff;
               end
            end else if (req_fire && action == ACT_BYTE) begin
               if (byte_last) begin
                  offset_in     = 16'd0;
                  header_in     = HDR_MIN;
                  pkt_len_in    = 16'd0;
                  bad_in        = byte_bad;
                  pend_valid_in = byte_valid;
                  pend_data_in  = byte_valid ? data_byte : 8'd0;
                  state_in      = ST_RD;
               end else begin
                  offset_in  = off_plus[15:0];
                  header_in  = hdr_new;
                  pkt_len_in = pkt_new;
                  if (byte_valid) begin
                     rsp_tvalid_in = 1'b1;
                     rsp_tdata_in  = data_byte;
                     rsp_tuser_in  = 3'b001;
                     rsp_tlast_in  = 1'b0;
                  end
               end
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (walk_stop) begin
               state_in = ST_FIN;
            end else begin
               elapsed_in = sub_res.diff;
               pos_in     = nxt_wrap ? '0 : nxt[POS_W-1:0];
               state_in   = ST_RD;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = pend_data_ff;
               rsp_tuser_in  = {bad_ff, !bad_ff && sub_res.borrow, pend_valid_ff};
               rsp_tlast_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         elapsed_ff    <= '0;
         pos_ff        <= '0;
         offset_ff     <= 16'd0;
         header_ff     <= HDR_MIN;
         pkt_len_ff    <= 16'd0;
         gw_ff         <= 8'd1;
         slen_ff       <= 7'd1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         elapsed_ff    <= elapsed_in;
         pos_ff        <= pos_in;
         offset_ff     <= offset_in;
         header_ff     <= header_in;
         pkt_len_ff    <= pkt_len_in;
         gw_ff         <= gw_in;
         slen_ff       <= slen_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      bad_ff        <= bad_in;
      pend_valid_ff <= pend_valid_in;
      pend_data_ff  <= pend_data_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tlast_ff  <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      CW'(pos_ff) < CW'(MAX_ENTRIES))
      else $error("schedule position out of range");

   a_walk_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && !walk_stop) |=> elapsed_ff < $past(elapsed_ff))
      else $error("walk step did not reduce elapsed seconds");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tdata == 8'd0)
      else $error("payload byte set without byte_valid");

   a_verdict_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2])) |-> rsp_tlast && !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("verdict flags outside packet end");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking bench for time_window_packet_gate: queued requests, burst/gap sender,
// stalling receiver, in-bench gate predictor and an inactivity watchdog.
// Depends on twpg_pkg and the time_window_packet_gate RTL only.
`timescale 1ns / 1ps

module testbench;
   import twpg_pkg::*;

   localparam logic [1:0] ACT_NONE    = 2'd3;
   localparam int         TABLE_DEPTH = 64;
   localparam int         LEN_HI_OFF  = 2;
   localparam int         LEN_LO_OFF  = 3;
   localparam int         SETTLE      = 12;
   localparam int         QUIET_LIMIT = 10000;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  data_byte;
      logic [5:0]  entry_index;
      logic [15:0] entry_value;
   } gate_req_type;

   typedef struct packed {
      logic [7:0] payload;
      logic       byte_valid;
      logic       packet_end;
      logic       forward;
      logic       malformed;
   } gate_rsp_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_SQUARE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_data = '0;

   time_window_packet_gate dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [7:0]  cfg_good_window = 8'd1;
   logic [6:0]  cfg_sched_len   = 7'd1;
   logic [31:0] gate_elapsed    = '0;
   logic [5:0]  sched_pos       = '0;
   logic [16:0] sched_iv [TABLE_DEPTH];
   int          gate_offset     = 0;
   int          gate_hdr        = HDR_MIN;
   int          gate_total      = 0;

   gate_req_type req_backlog [$];
   gate_rsp_type expected_gate_out [$];
   gate_req_type req_on_bus;
   int          queued_items = 0;
   int          mismatches   = 0;
   int          burst_left   = 0;
   int          gap_left     = 0;
   logic [15:0] rx_cycle     = '0;
   int          quiet_cycles = 0;

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++)
         sched_iv[i] = '0;
   end

   function automatic void forecast_gate_output(input gate_req_type r);
      int           off, h, end_len, nxt;
      bit           valid, last, bad, fwd;
      gate_rsp_type res;
      case (r.action)
         ACT_TICK: begin
            if (gate_elapsed != '1)
               gate_elapsed++;
         end
         ACT_LOAD: begin
            sched_iv[r.entry_index] = 17'(r.entry_value) + 17'(cfg_good_window);
         end
         ACT_BYTE: begin
            off = gate_offset;
            if (off == 0) begin
               h = int'(r.data_byte[3:0]) * 4;
               gate_hdr = (h < HDR_MIN) ? HDR_MIN : h;
            end else if (off == LEN_HI_OFF) begin
               gate_total = (gate_total & 'hff) | (int'(r.data_byte) << 8);
            end else if (off == LEN_LO_OFF) begin
               gate_total = (gate_total & 'hff00) | int'(r.data_byte);
            end
            valid = (off >= gate_hdr + UDP_HDR) && (off < gate_total);
            end_len = (gate_total < gate_hdr) ? gate_hdr : gate_total;
            last = (off >= LEN_LO_OFF) && (off + 1 >= end_len);
            bad = 1'b0;
            fwd = 1'b0;
            if (last) begin
               bad = gate_total < gate_hdr + UDP_HDR;
               // blackout walk: consume whole intervals, wrap at schedule length or table depth
               while (sched_iv[sched_pos] != 0 && gate_elapsed >= 32'(sched_iv[sched_pos])) begin
                  gate_elapsed -= 32'(sched_iv[sched_pos]);
                  nxt = int'(sched_pos) + 1;
                  if (nxt >= int'(cfg_sched_len) || nxt >= TABLE_DEPTH)
                     nxt = 0;
                  sched_pos = 6'(nxt);
               end
               fwd = !bad && (gate_elapsed < 32'(cfg_good_window));
               gate_offset = 0;
               gate_hdr = HDR_MIN;
               gate_total = 0;
            end else begin
               gate_offset = (off + 1) & 'hffff;
            end
            if (valid || last) begin
               res.payload    = valid ? r.data_byte : 8'h00;
               res.byte_valid = valid;
               res.packet_end = last;
               res.forward    = fwd;
               res.malformed  = bad;
               expected_gate_out = {expected_gate_out, res};
            end
         end
         default: ;
      endcase
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin : sender
      logic drive_next;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         drive_next = req_tvalid && !req_tready;
         if (req_tvalid && req_tready)
            forecast_gate_output(req_on_bus);
         if (!drive_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_backlog.size() > 0) begin
               req_on_bus = req_backlog.pop_front();
               req_tuser  <= req_on_bus.action;
               req_tdata  <= {2'b00, req_on_bus.entry_value, req_on_bus.entry_index,
                              req_on_bus.data_byte};
               drive_next = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_tvalid <= drive_next;
      end
   end

   // receiver: stall pattern steps through open, coin, sparse and square modes by rx_cycle[9:8]
   always @(posedge clock) begin : receiver
      gate_rsp_type seen, want;
      logic         ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.payload    = rsp_tdata;
            seen.byte_valid = rsp_tuser[0];
            seen.packet_end = rsp_tlast;
            seen.forward    = rsp_tuser[1];
            seen.malformed  = rsp_tuser[2];
            if (expected_gate_out.size() == 0) begin
               $display("%0t: result expected none actual %h", $time, seen);
               mismatches++;
            end else begin
               want = expected_gate_out.pop_front();
               check_field("payload_byte", int'(want.payload), int'(seen.payload));
               check_field("byte_valid", int'(want.byte_valid), int'(seen.byte_valid));
               check_field("packet_end", int'(want.packet_end), int'(seen.packet_end));
               check_field("forward", int'(want.forward), int'(seen.forward));
               check_field("malformed", int'(want.malformed), int'(seen.malformed));
            end
         end
         rx_cycle++;
         case (rx_mode_type'(rx_cycle[9:8]))
            RX_OPEN:   ready_next = 1'b1;
            RX_COIN:   ready_next = 1'($urandom_range(0, 1));
            RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
            default:   ready_next = rx_cycle[3];
         endcase
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic queue_req(input logic [1:0] act, input logic [7:0] b,
                            input logic [5:0] idx, input logic [15:0] val);
      gate_req_type r;
      r.action      = act;
      r.data_byte   = b;
      r.entry_index = idx;
      r.entry_value = val;
      req_backlog = {req_backlog, r};
      if (act != ACT_NONE)
         queued_items++;
   endtask

   task automatic push_packet(input int ihl, input int total, input bit noisy,
                              input bit alt_fill);
      int         hdr, span;
      logic [7:0] b;
      hdr  = (ihl * 4 < HDR_MIN) ? HDR_MIN : ihl * 4;
      span = (total > hdr) ? total : hdr;
      for (int k = 0; k < span; k++) begin
         if (k == 0)
            b = {4'($urandom), 4'(ihl)};
         else if (k == LEN_HI_OFF)
            b = 8'(total >> 8);
         else if (k == LEN_LO_OFF)
            b = 8'(total);
         else if (alt_fill)
            b = k[0] ? 8'hff : 8'h00;
         else
            b = 8'($urandom);
         if (noisy && $urandom_range(0, 9) == 0)
            queue_req(ACT_TICK, 8'($urandom), 6'($urandom), 16'($urandom));
         queue_req(ACT_BYTE, b, 6'($urandom), 16'($urandom));
      end
   endtask

   task automatic drain_wait;
      @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || expected_gate_out.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_GOOD_WINDOW)
         cfg_good_window = value;
      else
         cfg_sched_len = value[6:0];
      @(posedge clock);
   endtask

   task automatic apply_config(input int window, input int sched_len);
      drain_wait();
      csr_write(CSR_GOOD_WINDOW, 8'(window));
      csr_write(CSR_SCHED_LEN, 8'(sched_len));
   endtask

   task automatic run_random(input int budget);
      int stop, pick, ihl, hdr, total, idx, val;
      stop = queued_items + budget;
      while (queued_items < stop) begin
         pick = $urandom_range(0, 99);
         ihl  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
         hdr  = (ihl * 4 < HDR_MIN) ? HDR_MIN : ihl * 4;
         if (pick < 62) begin
            total = hdr + UDP_HDR + (($urandom_range(0, 39) == 0) ?
                    $urandom_range(60, 200) : $urandom_range(0, 12));
            push_packet(ihl, total, $urandom_range(0, 5) == 0, 1'b0);
         end else if (pick < 72) begin
            push_packet(ihl, $urandom_range(0, hdr + UDP_HDR - 1), 1'b0, 1'b0);
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 4))
               queue_req(ACT_TICK, 8'($urandom), 6'($urandom), 16'($urandom));
         end else if (pick < 96) begin
            idx = $urandom_range(0, 1) ? $urandom_range(0, TABLE_DEPTH - 1)
                                       : $urandom_range(0, int'(cfg_sched_len) - 1);
            val = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 24);
            queue_req(ACT_LOAD, 8'($urandom), 6'(idx), 16'(val));
         end else begin
            queue_req(ACT_NONE, 8'($urandom), 6'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);

      apply_config(4, 8);
      // every table entry gets loaded before the first packet ends
      for (int i = 0; i < TABLE_DEPTH; i++)
         queue_req(ACT_LOAD, 8'($urandom), 6'(i), 16'($urandom_range(0, 12)));

      queue_req(ACT_NONE, 8'hff, 6'h3f, 16'hffff);
      queue_req(ACT_LOAD, 8'h00, 6'd63, 16'hffff);
      queue_req(ACT_LOAD, 8'hff, 6'd0, 16'h0000);
      push_packet(5, 28, 1'b0, 1'b0);
      repeat (6) queue_req(ACT_TICK, 8'($urandom), 6'($urandom), 16'($urandom));
      push_packet(0, 30, 1'b0, 1'b1);
      push_packet(15, 68, 1'b0, 1'b0);
      push_packet(5, 10, 1'b0, 1'b0);
      push_packet(5, 24, 1'b0, 1'b0);
      push_packet(15, 0, 1'b0, 1'b0);
      repeat (40) queue_req(ACT_TICK, 8'($urandom), 6'($urandom), 16'($urandom));
      push_packet(5, 31, 1'b0, 1'b0);
      queue_req(ACT_LOAD, 8'($urandom), 6'd63, 16'd3);

      apply_config(1, 64);
      run_random(165);
      apply_config(255, 1);
      run_random(165);
      apply_config(17, 5);
      run_random(165);
      repeat (3) begin
         apply_config($urandom_range(1, 255), $urandom_range(1, 64));
         run_random(165);
      end

      drain_wait();
      if (mismatches == 0 && expected_gate_out.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
